// ===== hdl/single_wire_bus_master_top_assert.svh =====
// Assertion macros for the single-wire bus master top level.
// Expects signals clk and rst_n in the scope of each use.
`ifndef SINGLE_WIRE_BUS_MASTER_TOP_ASSERT_SVH
`define SINGLE_WIRE_BUS_MASTER_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define SWBM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("single_wire_bus_master: same-cycle check failed");

// Next-cycle implication, checked while out of reset
`define SWBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("single_wire_bus_master: next-cycle check failed");

`endif

// ===== hdl/swbm_pkg.sv =====
// Shared types, codes and constants of the single-wire bus master.
// No dependencies; used by every module of the block.
`default_nettype none

package swbm_pkg;

    // Mode codes on the input tuser field
    localparam logic [2:0] MODE_NONE     = 3'd0;
    localparam logic [2:0] MODE_DISCOVER = 3'd1;
    localparam logic [2:0] MODE_START    = 3'd2;
    localparam logic [2:0] MODE_SEND     = 3'd3;
    localparam logic [2:0] MODE_RECV     = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_CYCLES_PER_US = 3'd0;
    localparam logic [2:0] REG_BIT_FRAME_US  = 3'd1;
    localparam logic [2:0] REG_RESET_LOW_US  = 3'd2;
    localparam logic [2:0] REG_IDLE_HIGH_US  = 3'd3;
    localparam logic [2:0] REG_LOW_ZERO_US   = 3'd4;
    localparam logic [2:0] REG_LOW_ONE_US    = 3'd5;

    // Configuration reset values
    localparam logic [7:0] RST_CYCLES_PER_US = 8'd150;
    localparam logic [5:0] RST_BIT_FRAME_US  = 6'd20;
    localparam logic [7:0] RST_RESET_LOW_US  = 8'd175;
    localparam logic [7:0] RST_IDLE_HIGH_US  = 8'd160;
    localparam logic [4:0] RST_LOW_ZERO_US   = 5'd10;
    localparam logic [4:0] RST_LOW_ONE_US    = 5'd2;

    // Default parameter values
    localparam int RECOVERY_US_DEF         = 10;
    localparam int DISCOVERY_WINDOW_US_DEF = 6;
    localparam int DISCOVERY_ACK_US_DEF    = 24;
    localparam int QUEUE_DEPTH_DEF         = 2;

    // Widths
    localparam int LEN_W     = 16;  // segment lengths and timer
    localparam int SP_W      = 9;   // read sample point, c + c/5
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // c/5 as (c * 205) >> 10, exact for c below 1024
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;

    // Frame counts
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
    localparam logic [3:0] FRAMES_PER_BYTE = 4'd9;

    // Decoded command
    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_DISCOVER = 3'd1,
        CMD_START    = 3'd2,
        CMD_SEND     = 3'd3,
        CMD_RECV     = 3'd4
    } cmd_t;

    // Sequencer phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_RST_LOW = 6'b000010,
        PH_RST_REC = 6'b000100,
        PH_DISC    = 6'b001000,
        PH_HOLD    = 6'b010000,
        PH_FRAME   = 6'b100000
    } phase_t;

    // One classified tick
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       master_ack;
        logic       line_high;
    } entry_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Segment lengths in cycles, precomputed from configuration
    typedef struct packed {
        logic [7:0]      cyc;
        logic [LEN_W-1:0] rst_len;
        logic [LEN_W-1:0] rec_len;
        logic [LEN_W-1:0] win_len;
        logic [LEN_W-1:0] dack_len;
        logic [LEN_W-1:0] hold_len;
        logic [LEN_W-1:0] frame_len;
        logic [LEN_W-1:0] low0_len;
        logic [LEN_W-1:0] low1_len;
        logic [SP_W-1:0]  sample_pt;
    } timing_t;

endpackage

`default_nettype wire

// ===== hdl/swbm_front.sv =====
// Input stage: registers each tick from the slave stream and decodes its mode.
// Depends on swbm_pkg.
`default_nettype none

module swbm_front
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // s_tdata: tx_byte [7:0], master_ack [8], line_high [9], zero [15:10]
    input  wire logic [swbm_pkg::IN_TDATA_W-1:0]      s_tdata,
    // s_tuser: mode [2:0]
    input  wire logic [2:0]                           s_tuser,
    input  wire swbm_pkg::q_status_t                  q_stat,
    output logic                                      q_push,
    output swbm_pkg::entry_t                          q_wdata
);

    logic             valid_reg;
    swbm_pkg::entry_t entry_reg;
    swbm_pkg::entry_t entry_next;

    // Take a new transfer when the stage is empty or drains this cycle
    assign s_tready = !valid_reg || !q_stat.full;
    assign q_push   = valid_reg && !q_stat.full;
    assign q_wdata  = entry_reg;

    // Decode the mode; unused codes start nothing
    always_comb
    begin
        entry_next.tx_byte    = s_tdata[7:0];
        entry_next.master_ack = s_tdata[8];
        entry_next.line_high  = s_tdata[9];
        case (s_tuser)
            swbm_pkg::MODE_DISCOVER: entry_next.cmd = swbm_pkg::CMD_DISCOVER;
            swbm_pkg::MODE_START:    entry_next.cmd = swbm_pkg::CMD_START;
            swbm_pkg::MODE_SEND:     entry_next.cmd = swbm_pkg::CMD_SEND;
            swbm_pkg::MODE_RECV:     entry_next.cmd = swbm_pkg::CMD_RECV;
            default:                 entry_next.cmd = swbm_pkg::CMD_NONE;
        endcase
    end

    // Hold the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Capture payload on each transfer
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/swbm_queue.sv =====
// Short queue between the decode stage and the sequencer.
// Depends on swbm_pkg.
`default_nettype none

module swbm_queue
#(
    parameter int DEPTH = swbm_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire swbm_pkg::entry_t wdata,
    input  wire logic             pop,
    output swbm_pkg::entry_t      rdata,
    output swbm_pkg::q_status_t   stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    swbm_pkg::entry_t slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = slots[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/swbm_timing.sv =====
// Configuration registers and the segment lengths derived from them.
// Depends on swbm_pkg.
`default_nettype none

module swbm_timing
#(
    parameter int RECOVERY_US         = swbm_pkg::RECOVERY_US_DEF,
    parameter int DISCOVERY_WINDOW_US = swbm_pkg::DISCOVERY_WINDOW_US_DEF,
    parameter int DISCOVERY_ACK_US    = swbm_pkg::DISCOVERY_ACK_US_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    output swbm_pkg::timing_t tim
);

    localparam int LW = swbm_pkg::LEN_W;
    localparam int SW = swbm_pkg::SP_W;

    logic [7:0] cyc_us_reg;
    logic [5:0] frame_us_reg;
    logic [7:0] rst_us_reg;
    logic [7:0] idle_us_reg;
    logic [4:0] low0_us_reg;
    logic [4:0] low1_us_reg;

    logic [7:0]    c_eff;
    logic [7:0]    rst_eff;
    logic [7:0]    idle_eff;
    logic [5:0]    frame_eff;
    logic [4:0]    low0_eff;
    logic [4:0]    low1_eff;
    logic [LW-1:0] div5_prod;
    swbm_pkg::timing_t tim_next;

    // Write configuration; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_us_reg   <= swbm_pkg::RST_CYCLES_PER_US;
            frame_us_reg <= swbm_pkg::RST_BIT_FRAME_US;
            rst_us_reg   <= swbm_pkg::RST_RESET_LOW_US;
            idle_us_reg  <= swbm_pkg::RST_IDLE_HIGH_US;
            low0_us_reg  <= swbm_pkg::RST_LOW_ZERO_US;
            low1_us_reg  <= swbm_pkg::RST_LOW_ONE_US;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swbm_pkg::REG_CYCLES_PER_US: cyc_us_reg   <= cfg_wdata;
                swbm_pkg::REG_BIT_FRAME_US:  frame_us_reg <= cfg_wdata[5:0];
                swbm_pkg::REG_RESET_LOW_US:  rst_us_reg   <= cfg_wdata;
                swbm_pkg::REG_IDLE_HIGH_US:  idle_us_reg  <= cfg_wdata;
                swbm_pkg::REG_LOW_ZERO_US:   low0_us_reg  <= cfg_wdata[4:0];
                swbm_pkg::REG_LOW_ONE_US:    low1_us_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // A zero register counts as one
    assign c_eff     = (cyc_us_reg   == '0) ? 8'd1 : cyc_us_reg;
    assign rst_eff   = (rst_us_reg   == '0) ? 8'd1 : rst_us_reg;
    assign idle_eff  = (idle_us_reg  == '0) ? 8'd1 : idle_us_reg;
    assign frame_eff = (frame_us_reg == '0) ? 6'd1 : frame_us_reg;
    assign low0_eff  = (low0_us_reg  == '0) ? 5'd1 : low0_us_reg;
    assign low1_eff  = (low1_us_reg  == '0) ? 5'd1 : low1_us_reg;

    assign div5_prod = LW'(c_eff) * LW'(swbm_pkg::DIV5_MUL);

    // Scale each interval by cycles per microsecond; the read sample point is c + c/5
    always_comb
    begin
        tim_next.cyc       = c_eff;
        tim_next.rst_len   = LW'(rst_eff) * LW'(c_eff);
        tim_next.rec_len   = LW'(RECOVERY_US) * LW'(c_eff);
        tim_next.win_len   = LW'(DISCOVERY_WINDOW_US) * LW'(c_eff);
        tim_next.dack_len  = LW'(DISCOVERY_ACK_US) * LW'(c_eff);
        tim_next.hold_len  = LW'(idle_eff) * LW'(c_eff);
        tim_next.frame_len = LW'(frame_eff) * LW'(c_eff);
        tim_next.low0_len  = LW'(low0_eff) * LW'(c_eff);
        tim_next.low1_len  = LW'(low1_eff) * LW'(c_eff);
        tim_next.sample_pt = SW'(c_eff) + SW'(div5_prod >> swbm_pkg::DIV5_SHIFT);
    end

    // Register the lengths every cycle
    always_ff @(posedge clk)
    begin
        tim <= tim_next;
    end

endmodule

`default_nettype wire

// ===== hdl/swbm_back.sv =====
// Bit-timing sequencer: one queued tick per step, result held in an output register.
// Depends on swbm_pkg.
`default_nettype none

module swbm_back
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire swbm_pkg::timing_t                 tim,
    input  wire swbm_pkg::entry_t                  q_rdata,
    input  wire swbm_pkg::q_status_t               q_stat,
    output logic                                   q_pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: drive_low [0], busy_res [1], acked [2], rx_byte [10:3], zero [15:11]
    output logic [swbm_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // m_tlast: done_res
    output logic                                   m_tlast
);

    localparam int LW  = swbm_pkg::LEN_W;
    localparam int PAD = swbm_pkg::OUT_TDATA_W - 11;

    swbm_pkg::phase_t phase_reg, phase_next, ph_e;
    swbm_pkg::cmd_t   cmd_reg, cmd_next, cmd_e;
    logic [LW-1:0]    timer_reg, timer_next, t_e;
    logic [3:0]       bit_index_reg, bit_index_next, bi_e;
    logic [7:0]       shift_reg, shift_next, sb_e;
    logic             presence_reg, presence_next, pres_e;
    logic             pma_reg, pma_e;
    logic             ack_reg, ack_next;
    logic [7:0]       rx_reg, rx_next;

    logic             out_valid_reg;
    logic             out_drive_reg, out_busy_reg, out_done_reg;
    logic             drive, busy, done;
    logic             seg_end, reading, tx_bit;
    logic [LW:0]      t_inc;
    logic [LW-1:0]    low_len;

    assign q_pop = !q_stat.empty && (!out_valid_reg || m_tready);

    // Step the sequencer for the tick at the queue head
    always_comb
    begin
        ph_e   = phase_reg;
        cmd_e  = cmd_reg;
        t_e    = timer_reg;
        bi_e   = bit_index_reg;
        sb_e   = shift_reg;
        pres_e = presence_reg;
        pma_e  = pma_reg;

        // Start a command only from idle
        if (phase_reg == swbm_pkg::PH_IDLE && q_rdata.cmd != swbm_pkg::CMD_NONE)
        begin
            cmd_e  = q_rdata.cmd;
            t_e    = '0;
            bi_e   = '0;
            pres_e = 1'b0;
            case (q_rdata.cmd)
                swbm_pkg::CMD_DISCOVER: ph_e = swbm_pkg::PH_RST_LOW;
                swbm_pkg::CMD_START:    ph_e = swbm_pkg::PH_HOLD;
                default:
                begin
                    ph_e  = swbm_pkg::PH_FRAME;
                    sb_e  = (q_rdata.cmd == swbm_pkg::CMD_SEND) ? q_rdata.tx_byte : 8'd0;
                    pma_e = q_rdata.master_ack;
                end
            endcase
        end

        t_inc   = {1'b0, t_e} + 1'b1;
        reading = (cmd_e == swbm_pkg::CMD_SEND) ? (bi_e >= swbm_pkg::BITS_PER_BYTE)
                                                : (bi_e <  swbm_pkg::BITS_PER_BYTE);
        // MSB first: bit 7 - index, which is the inverted low index bits
        tx_bit  = (cmd_e == swbm_pkg::CMD_SEND) ? sb_e[~bi_e[2:0]] : !pma_e;
        low_len = tx_bit ? tim.low1_len : tim.low0_len;

        drive         = 1'b0;
        seg_end       = 1'b0;
        presence_next = pres_e;
        shift_next    = sb_e;

        // Drive the line and find the segment end
        case (ph_e)
            swbm_pkg::PH_RST_LOW:
            begin
                drive   = 1'b1;
                seg_end = (t_inc >= {1'b0, tim.rst_len});
            end
            swbm_pkg::PH_RST_REC:
            begin
                seg_end = (t_inc >= {1'b0, tim.rec_len});
            end
            swbm_pkg::PH_DISC:
            begin
                seg_end = (t_inc >= {1'b0, tim.dack_len}) && (t_inc >= {1'b0, tim.win_len})
                       && (t_inc >= (LW+1)'(tim.cyc));
                if (t_e < LW'(tim.cyc))
                begin
                    drive = 1'b1;
                end
                else if (t_e < tim.win_len && !q_rdata.line_high)
                begin
                    presence_next = 1'b1;
                end
            end
            swbm_pkg::PH_HOLD:
            begin
                seg_end = (t_inc >= {1'b0, tim.hold_len});
            end
            swbm_pkg::PH_FRAME:
            begin
                if (reading)
                begin
                    drive   = (t_e < LW'(tim.cyc));
                    seg_end = (t_inc >= {1'b0, tim.frame_len}) && (t_e >= LW'(tim.sample_pt));
                    if (t_e == LW'(tim.sample_pt))
                    begin
                        if (cmd_e == swbm_pkg::CMD_SEND)
                        begin
                            presence_next = !q_rdata.line_high;
                        end
                        else
                        begin
                            shift_next = {sb_e[6:0], q_rdata.line_high};
                        end
                    end
                end
                else
                begin
                    drive   = (t_e < low_len);
                    seg_end = (t_inc >= {1'b0, tim.frame_len}) && (t_inc >= {1'b0, low_len});
                end
            end
            default: ;
        endcase

        phase_next     = ph_e;
        cmd_next       = cmd_e;
        timer_next     = t_e;
        bit_index_next = bi_e;
        ack_next       = ack_reg;
        rx_next        = rx_reg;
        done           = 1'b0;
        busy           = (ph_e != swbm_pkg::PH_IDLE);

        // Advance to the next segment or finish
        if (busy)
        begin
            if (seg_end)
            begin
                timer_next = '0;
                case (ph_e)
                    swbm_pkg::PH_RST_LOW: phase_next = swbm_pkg::PH_RST_REC;
                    swbm_pkg::PH_RST_REC: phase_next = swbm_pkg::PH_DISC;
                    swbm_pkg::PH_DISC:    phase_next = swbm_pkg::PH_HOLD;
                    swbm_pkg::PH_HOLD:
                    begin
                        if (cmd_e == swbm_pkg::CMD_DISCOVER)
                        begin
                            ack_next = presence_next;
                        end
                        done = 1'b1;
                    end
                    swbm_pkg::PH_FRAME:
                    begin
                        bit_index_next = bi_e + 4'd1;
                        if (bit_index_next >= swbm_pkg::FRAMES_PER_BYTE)
                        begin
                            if (cmd_e == swbm_pkg::CMD_SEND)
                            begin
                                ack_next = presence_next;
                            end
                            else
                            begin
                                rx_next = shift_next;
                            end
                            done = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (done)
                begin
                    phase_next     = swbm_pkg::PH_IDLE;
                    cmd_next       = swbm_pkg::CMD_NONE;
                    bit_index_next = '0;
                end
            end
            else
            begin
                timer_next = t_inc[LW-1:0];
            end
        end
    end

    // Commit the step and load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= swbm_pkg::PH_IDLE;
            cmd_reg       <= swbm_pkg::CMD_NONE;
            timer_reg     <= '0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b0;
            pma_reg       <= 1'b0;
            ack_reg       <= 1'b0;
            rx_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                cmd_reg       <= cmd_next;
                timer_reg     <= timer_next;
                bit_index_reg <= bit_index_next;
                shift_reg     <= shift_next;
                presence_reg  <= presence_next;
                pma_reg       <= pma_e;
                ack_reg       <= ack_next;
                rx_reg        <= rx_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold per-tick line outputs with the result
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_drive_reg <= drive;
            out_busy_reg  <= busy;
            out_done_reg  <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {{PAD{1'b0}}, rx_reg, ack_reg, out_busy_reg, out_drive_reg};

endmodule

`default_nettype wire

// ===== hdl/single_wire_bus_master_top.sv =====
// Single-wire bus master: input stage, tick queue, timing registers, sequencer.
// Depends on swbm_pkg, swbm_front, swbm_queue, swbm_timing, swbm_back and the assert header.
//
// Usage:
//   The slave stream carries one clock tick of bus timing per transfer: the mode in
//   s_tuser, the byte to send, the master ACK flag and the sampled line level in s_tdata.
//   The master stream returns one result per tick: drive_low, busy_res, acked and rx_byte
//   in m_tdata, and done_res on m_tlast for the last tick of a command.
//   A command is taken only on a tick where the sequencer is idle; otherwise mode is ignored.
//   The user must write timing registers via cfg_we / cfg_index / cfg_wdata only while no
//   tick is in flight; the block does not enforce this. Indexes past the list are dropped.
//   Path: a tick passes the input stage register and the queue to the output register.
//   Throughput: one tick per cycle while m_tready is high; the sequencer updates its phase,
//   timer and bit counter in a single step per tick.
//   Reset: registers return to their defaults, the sequencer goes idle and no result
//   is pending.
//   Stall: a result waiting on m_tready stays in the output register; ticks collect in
//   the input stage and the queue, and s_tready drops once both are full.
`default_nettype none

module single_wire_bus_master_top
#(
    parameter int RECOVERY_US         = swbm_pkg::RECOVERY_US_DEF,
    parameter int DISCOVERY_WINDOW_US = swbm_pkg::DISCOVERY_WINDOW_US_DEF,
    parameter int DISCOVERY_ACK_US    = swbm_pkg::DISCOVERY_ACK_US_DEF,
    parameter int QUEUE_DEPTH         = swbm_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: tx_byte [7:0], master_ack [8], line_high [9], zero [15:10]
    input  wire logic [swbm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser: mode [2:0]
    input  wire logic [2:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: drive_low [0], busy_res [1], acked [2], rx_byte [10:3], zero [15:11]
    output logic [swbm_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // m_tlast: done_res
    output logic                                    m_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [7:0]                         cfg_wdata
);

    `include "single_wire_bus_master_top_assert.svh"

    swbm_pkg::q_status_t q_stat;
    swbm_pkg::entry_t    q_wdata;
    swbm_pkg::entry_t    q_rdata;
    swbm_pkg::timing_t   tim;
    logic                q_push;
    logic                q_pop;

    swbm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    swbm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    swbm_timing
    #(
        .RECOVERY_US         (RECOVERY_US),
        .DISCOVERY_WINDOW_US (DISCOVERY_WINDOW_US),
        .DISCOVERY_ACK_US    (DISCOVERY_ACK_US)
    ) u_timing
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tim       (tim)
    );

    swbm_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tim      (tim),
        .q_rdata  (q_rdata),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A finishing tick always belongs to a command
    `SWBM_ASSERT_IMPL(a_done_is_busy, m_tvalid && m_tlast, m_tdata[1])
    // The input stage never writes a full queue
    `SWBM_ASSERT_IMPL(a_push_has_room, q_push, !q_stat.full)
    // The sequencer never steps on an empty queue
    `SWBM_ASSERT_IMPL(a_pop_has_data, q_pop, !q_stat.empty)
    // A write without a read leaves the queue occupied
    `SWBM_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty)

endmodule

`default_nettype wire
